/* sv/bresenham_line_generator_defines.svh */
// ----------------------------------------------------------------------------
// bresenham_line_generator_defines
// Assertion macros shared by the checker files of the line generator.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_GENERATOR_DEFINES_SVH
`define BRESENHAM_LINE_GENERATOR_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define BLG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define BLG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/blg_pkg.sv */
// ----------------------------------------------------------------------------
// blg_pkg
// Types and constants shared by the line generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package blg_pkg;

    localparam int COORD_BITS        = 12;
    localparam int COLOR_BITS        = 8;
    localparam int TWICE_BITS        = COORD_BITS + 1;
    localparam int ERR_BITS          = COORD_BITS + 3;
    localparam int QUEUE_DEPTH_DEF   = 2;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } blg_func_t;

    // Input transaction
    typedef struct packed {
        blg_func_t                     func;
        logic signed [COORD_BITS-1:0]  x_start;
        logic signed [COORD_BITS-1:0]  y_start;
        logic signed [COORD_BITS-1:0]  x_end;
        logic signed [COORD_BITS-1:0]  y_end;
        logic        [COLOR_BITS-1:0]  color;
    } blg_in_t;

    // Output transaction
    typedef struct packed {
        logic signed [COORD_BITS-1:0]  pixel_x;
        logic signed [COORD_BITS-1:0]  pixel_y;
        logic        [COLOR_BITS-1:0]  pixel_color;
        logic                          last;
    } blg_pix_t;

    // Classified command held in the queue between front and back
    typedef struct packed {
        blg_func_t                     func;
        logic                          steep;
        logic                          minor_down;
        logic signed [COORD_BITS-1:0]  major_start;
        logic signed [COORD_BITS-1:0]  minor_start;
        logic signed [COORD_BITS-1:0]  major_end;
        logic        [COORD_BITS-1:0]  span_major;
        logic        [COORD_BITS-1:0]  span_minor;
        logic        [COLOR_BITS-1:0]  color;
    } blg_cmd_t;

endpackage

`default_nettype wire

/* sv/bresenham_line_generator.sv */
// An accepted command is first registered in the queue; the back end then takes it from the
// queue head and registers its pixel in the pixel register.
// Throughput: one command per cycle while the output is not stalled, each giving at most one
// pixel, set by the single add-and-compare on the error term in the back end.
// The command queue lets input run up to QUEUE_DEPTH commands ahead of a stalled output.
// Reset: asynchronous, active low; queue empty, no line in progress, no pixel pending.
// ----------------------------------------------------------------------------
// bresenham_line_generator
// Line rasterizer: front end sets up lines, queue decouples, back end walks.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_generator
    import blg_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            cmd_valid,
    output logic           cmd_ready,
    input  wire blg_in_t   cmd,
    output logic           pix_valid,
    input  wire            pix_ready,
    output blg_pix_t       pix
);

    blg_cmd_t  front_cmd;
    blg_cmd_t  head_cmd;
    logic      head_valid;
    logic      head_ready;

    // Classify and set up
    blg_front u_front (
        .item (cmd),
        .cmd  (front_cmd)
    );

    // Decouple front and back
    blg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_valid),
        .push_ready (cmd_ready),
        .push_data  (front_cmd),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_data   (head_cmd)
    );

    // Walk lines and emit pixels
    blg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd_ready (head_ready),
        .cmd       (head_cmd),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

endmodule

`default_nettype wire

/* sv/blg_front.sv */
// ----------------------------------------------------------------------------
// blg_front
// Classifies input transactions and works out the line setup for starts:
// axis swap, endpoint order, spans and minor direction.
// ----------------------------------------------------------------------------
`default_nettype none

module blg_front
    import blg_pkg::*;
(
    input  wire blg_in_t   item,
    output blg_cmd_t       cmd
);

    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic signed [COORD_BITS:0]   ndx;
    logic signed [COORD_BITS:0]   ndy;
    logic        [COORD_BITS-1:0] adx;
    logic        [COORD_BITS-1:0] ady;
    logic                         steep;
    logic signed [COORD_BITS-1:0] a0;
    logic signed [COORD_BITS-1:0] b0;
    logic signed [COORD_BITS-1:0] a1;
    logic signed [COORD_BITS-1:0] b1;
    logic                         order_swap;
    logic signed [COORD_BITS-1:0] minor_first;
    logic signed [COORD_BITS-1:0] minor_last;

    // Take absolute deltas of both axes
    always_comb
    begin
        dx  = $signed({item.x_end[COORD_BITS-1], item.x_end})
            - $signed({item.x_start[COORD_BITS-1], item.x_start});
        dy  = $signed({item.y_end[COORD_BITS-1], item.y_end})
            - $signed({item.y_start[COORD_BITS-1], item.y_start});
        ndx = -dx;
        ndy = -dy;
        adx = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ady = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        steep = (ady > adx);
    end

    // Swap axes for steep lines, then order endpoints along the major axis
    always_comb
    begin
        a0 = steep ? item.y_start : item.x_start;
        b0 = steep ? item.x_start : item.y_start;
        a1 = steep ? item.y_end   : item.x_end;
        b1 = steep ? item.x_end   : item.y_end;
        order_swap  = (a0 > a1);
        minor_first = order_swap ? b1 : b0;
        minor_last  = order_swap ? b0 : b1;

        cmd.func        = item.func;
        cmd.steep       = steep;
        cmd.minor_down  = !(minor_first < minor_last);
        cmd.major_start = order_swap ? a1 : a0;
        cmd.minor_start = minor_first;
        cmd.major_end   = order_swap ? a0 : a1;
        cmd.span_major  = steep ? ady : adx;
        cmd.span_minor  = steep ? adx : ady;
        cmd.color       = item.color;
    end

endmodule

`default_nettype wire

/* sv/blg_queue.sv */
// ----------------------------------------------------------------------------
// blg_queue
// Short command queue between the front and the back, so each side
// can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module blg_queue
    import blg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push_valid,
    output logic           push_ready,
    input  wire blg_cmd_t  push_data,
    output logic           pop_valid,
    input  wire            pop_ready,
    output blg_cmd_t       pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    blg_cmd_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* sv/blg_back.sv */
// ----------------------------------------------------------------------------
// blg_back
// Walks the line: loads setup on start, steps the error term on each
// step command while a line is in progress and drives the registered pixel output.
// ----------------------------------------------------------------------------
`default_nettype none

module blg_back
    import blg_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            cmd_valid,
    output logic           cmd_ready,
    input  wire blg_cmd_t  cmd,
    output logic           pix_valid,
    input  wire            pix_ready,
    output blg_pix_t       pix
);

    logic signed [COORD_BITS-1:0] major_pos_reg, major_pos_next;
    logic signed [COORD_BITS-1:0] minor_pos_reg, minor_pos_next;
    logic signed [COORD_BITS-1:0] major_end_reg, major_end_next;
    logic signed [ERR_BITS-1:0]   error_reg, error_next;
    logic        [TWICE_BITS-1:0] twice_dx_reg, twice_dx_next;
    logic        [TWICE_BITS-1:0] twice_dy_reg, twice_dy_next;
    logic                         minor_down_reg, minor_down_next;
    logic                         steep_reg, steep_next;
    logic                         busy_reg, busy_next;
    logic        [COLOR_BITS-1:0] color_reg, color_next;
    logic                         pix_valid_reg, pix_valid_next;
    blg_pix_t                     pix_reg, pix_next;

    logic                         advance;
    logic signed [ERR_BITS-1:0]   err_sub;
    logic signed [ERR_BITS-1:0]   err_step;
    logic signed [COORD_BITS-1:0] minor_step;
    logic signed [COORD_BITS-1:0] major_step;
    logic                         step_last;
    logic                         start_last;

    assign advance   = !pix_valid_reg || pix_ready;
    assign cmd_ready = advance;
    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    // Error-term step: subtract 2*dy, move minor and add 2*dx back on underflow
    always_comb
    begin
        err_sub = error_reg - $signed({2'b00, twice_dy_reg});
        if (err_sub < 0)
        begin
            err_step   = err_sub + $signed({2'b00, twice_dx_reg});
            minor_step = minor_down_reg ? minor_pos_reg - 1'b1 : minor_pos_reg + 1'b1;
        end
        else
        begin
            err_step   = err_sub;
            minor_step = minor_pos_reg;
        end
        major_step = major_pos_reg + 1'b1;
        step_last  = (major_step >= major_end_reg);
        start_last = (cmd.major_start == cmd.major_end);
    end

    // Execute the command at the head of the queue
    always_comb
    begin
        major_pos_next  = major_pos_reg;
        minor_pos_next  = minor_pos_reg;
        major_end_next  = major_end_reg;
        error_next      = error_reg;
        twice_dx_next   = twice_dx_reg;
        twice_dy_next   = twice_dy_reg;
        minor_down_next = minor_down_reg;
        steep_next      = steep_reg;
        busy_next       = busy_reg;
        color_next      = color_reg;
        pix_valid_next  = pix_valid_reg;
        pix_next        = pix_reg;

        if (advance)
        begin
            pix_valid_next = 1'b0;
            if (cmd_valid)
            begin
                case (cmd.func)
                    FUNC_START:
                    begin
                        major_pos_next   = cmd.major_start;
                        minor_pos_next   = cmd.minor_start;
                        major_end_next   = cmd.major_end;
                        error_next       = $signed({3'b000, cmd.span_major});
                        twice_dx_next    = {cmd.span_major, 1'b0};
                        twice_dy_next    = {cmd.span_minor, 1'b0};
                        minor_down_next  = cmd.minor_down;
                        steep_next       = cmd.steep;
                        busy_next        = !start_last;
                        color_next       = cmd.color;
                        pix_valid_next   = 1'b1;
                        pix_next.pixel_x = cmd.steep ? cmd.minor_start : cmd.major_start;
                        pix_next.pixel_y = cmd.steep ? cmd.major_start : cmd.minor_start;
                        pix_next.pixel_color = cmd.color;
                        pix_next.last    = start_last;
                    end
                    FUNC_STEP:
                    begin
                        // Drop a step while idle
                        if (busy_reg)
                        begin
                            major_pos_next   = major_step;
                            minor_pos_next   = minor_step;
                            error_next       = err_step;
                            busy_next        = !step_last;
                            pix_valid_next   = 1'b1;
                            pix_next.pixel_x = steep_reg ? minor_step : major_step;
                            pix_next.pixel_y = steep_reg ? major_step : minor_step;
                            pix_next.pixel_color = color_reg;
                            pix_next.last    = step_last;
                        end
                    end
                    default:
                    begin
                        busy_next = busy_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // Hold line state and output payload
    always_ff @(posedge clk)
    begin
        major_pos_reg  <= major_pos_next;
        minor_pos_reg  <= minor_pos_next;
        major_end_reg  <= major_end_next;
        error_reg      <= error_next;
        twice_dx_reg   <= twice_dx_next;
        twice_dy_reg   <= twice_dy_next;
        minor_down_reg <= minor_down_next;
        steep_reg      <= steep_next;
        color_reg      <= color_next;
        pix_reg        <= pix_next;
    end

endmodule

`default_nettype wire

/* sv/blg_checker.sv */
// ----------------------------------------------------------------------------
// blg_checker
// Port-level checks of the line generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bresenham_line_generator_defines.svh"

module blg_checker
    import blg_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            cmd_ready,
    input  wire            pix_valid,
    input  wire            pix_ready,
    input  wire blg_pix_t  pix
);

    // A stalled pixel transaction holds
    `BLG_ASSERT_NEXT(a_pix_hold, pix_valid && !pix_ready, pix_valid && $stable(pix), "pixel changed while stalled")

    // No pixel right after reset release
    `BLG_ASSERT_NOW(a_pix_after_reset, !$past(rst_n), !pix_valid, "pixel valid right after reset")

    // The queue fills only behind a pending pixel
    `BLG_ASSERT_NOW(a_full_needs_stall, !cmd_ready, pix_valid, "input stalled with no pixel pending")

    // A full queue with a stalled output stays full
    `BLG_ASSERT_NEXT(a_full_holds, !cmd_ready && !pix_ready, !cmd_ready, "input ready without output progress")

endmodule

bind bresenham_line_generator blg_checker u_blg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd_ready),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
);

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line generator. A tracker class follows the
// walk along the major axis for every accepted command and queues the pixels
// it should produce. Each pixel the block hands out is compared field by
// field with the oldest queued pixel. Commands are mostly complete lines with
// random endpoints, mixed with abandoned lines, steps issued while idle and
// one line across the whole coordinate range. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import blg_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;

    // Track the line walk and hold the pixels still owed by the block
    class line_tracker;
        int major_pos;
        int minor_pos;
        int major_end;
        int error_term;
        int twice_dx;
        int twice_dy;
        bit minor_down;
        bit steep;
        bit busy;
        logic [COLOR_BITS-1:0] line_color;
        blg_pix_t owed_pixels[$];
        int errors;

        function new();
            major_pos = 0;
            minor_pos = 0;
            major_end = 0;
            error_term = 0;
            twice_dx = 0;
            twice_dy = 0;
            minor_down = 0;
            steep = 0;
            busy = 0;
            line_color = '0;
            errors = 0;
        endfunction

        function void queue_pixel(bit is_last);
            blg_pix_t p;
            int px;
            int py;
            px = steep ? minor_pos : major_pos;
            py = steep ? major_pos : minor_pos;
            p.pixel_x = px[COORD_BITS-1:0];
            p.pixel_y = py[COORD_BITS-1:0];
            p.pixel_color = line_color;
            p.last = is_last;
            owed_pixels.insert(owed_pixels.size(), p);
        endfunction

        // Advance the walk for one accepted command
        function void trace_command(blg_in_t c);
            int a0;
            int b0;
            int a1;
            int b1;
            int t;
            int span_a;
            int span_b;
            bit fin;
            if (c.func == FUNC_START) begin
                a0 = $signed(c.x_start);
                b0 = $signed(c.y_start);
                a1 = $signed(c.x_end);
                b1 = $signed(c.y_end);
                line_color = c.color;
                span_a = (a1 > a0) ? a1 - a0 : a0 - a1;
                span_b = (b1 > b0) ? b1 - b0 : b0 - b1;
                steep = span_b > span_a;
                // swap axes so the walk runs along the longer span
                if (steep) begin
                    t = a0; a0 = b0; b0 = t;
                    t = a1; a1 = b1; b1 = t;
                end
                // order endpoints by increasing major coordinate
                if (a0 > a1) begin
                    t = a0; a0 = a1; a1 = t;
                    t = b0; b0 = b1; b1 = t;
                end
                major_pos = a0;
                minor_pos = b0;
                major_end = a1;
                twice_dx = 2 * (a1 - a0);
                twice_dy = 2 * ((b1 > b0) ? b1 - b0 : b0 - b1);
                error_term = a1 - a0;
                minor_down = !(b0 < b1);
                fin = (major_pos == major_end);
                busy = !fin;
                queue_pixel(fin);
            end
            else if (busy) begin
                error_term -= twice_dy;
                if (error_term < 0) begin
                    minor_pos += minor_down ? -1 : 1;
                    error_term += twice_dx;
                end
                major_pos += 1;
                fin = (major_pos >= major_end);
                busy = !fin;
                queue_pixel(fin);
            end
        endfunction

        // Compare one handed-out pixel with the oldest owed pixel
        function void check_pixel(blg_pix_t got);
            blg_pix_t want;
            if (owed_pixels.size() == 0) begin
                errors++;
                $display("%0t: pixel expected none actual x=%0d y=%0d color=%0h last=%0b",
                         $time, got.pixel_x, got.pixel_y, got.pixel_color, got.last);
                return;
            end
            want = owed_pixels.pop_front();
            if (got.pixel_x !== want.pixel_x) begin
                errors++;
                $display("%0t: pixel_x expected %0d actual %0d",
                         $time, want.pixel_x, got.pixel_x);
            end
            if (got.pixel_y !== want.pixel_y) begin
                errors++;
                $display("%0t: pixel_y expected %0d actual %0d",
                         $time, want.pixel_y, got.pixel_y);
            end
            if (got.pixel_color !== want.pixel_color) begin
                errors++;
                $display("%0t: pixel_color expected %0h actual %0h",
                         $time, want.pixel_color, got.pixel_color);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last expected %0b actual %0b",
                         $time, want.last, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    blg_in_t cmd = '0;
    logic pix_valid;
    logic pix_ready = 1'b0;
    blg_pix_t pix;

    line_tracker tracker = new();
    int cycle_count = 0;
    int sent_items = 0;
    bit no_idle = 1'b0;

    bresenham_line_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Record accepted commands first, then check the pixel of this edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (cmd_valid && cmd_ready)
                tracker.trace_command(cmd);
            if (pix_valid && pix_ready)
                tracker.check_pixel(pix);
        end
    end

    // Stall the pixel side for a random number of cycles per transaction
    initial begin : pixel_sink
        int hold;
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 4);
            if (hold > 0) begin
                pix_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            pix_ready <= 1'b1;
            do @(posedge clk); while (!(pix_valid && pix_ready));
            @(negedge clk);
        end
    end

    // Offer one command after a random gap and hold it until accepted
    task automatic send_command(blg_in_t item);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd <= item;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        sent_items++;
        @(negedge clk);
    endtask

    // Start a line and follow it with a number of step requests
    task automatic draw_line(int x0, int y0, int x1, int y1, logic [COLOR_BITS-1:0] color,
                             int steps);
        blg_in_t item;
        item.func = FUNC_START;
        item.x_start = x0[COORD_BITS-1:0];
        item.y_start = y0[COORD_BITS-1:0];
        item.x_end = x1[COORD_BITS-1:0];
        item.y_end = y1[COORD_BITS-1:0];
        item.color = color;
        send_command(item);
        // step payload is ignored, so fill it with noise
        for (int i = 0; i < steps; i++) begin
            item.func = FUNC_STEP;
            item.x_start = COORD_BITS'($urandom);
            item.y_start = COORD_BITS'($urandom);
            item.x_end = COORD_BITS'($urandom);
            item.y_end = COORD_BITS'($urandom);
            item.color = COLOR_BITS'($urandom);
            send_command(item);
        end
    endtask

    // Issue a step with no line in progress
    task automatic idle_step(logic [COORD_BITS-1:0] fill, logic [COLOR_BITS-1:0] color);
        blg_in_t item;
        item.func = FUNC_STEP;
        item.x_start = fill;
        item.y_start = fill;
        item.x_end = fill;
        item.y_end = fill;
        item.color = color;
        send_command(item);
    endtask

    // Pick a coordinate close to another, kept inside the range
    function automatic int near_coord(int c);
        int d;
        d = int'($urandom_range(0, 24)) - 12;
        if (c + d > COORD_MAX || c + d < COORD_MIN)
            return c - d;
        return c + d;
    endfunction

    initial begin : stimulus
        int x0;
        int y0;
        int x1;
        int y1;
        int span_x;
        int span_y;
        int span;
        int pick;
        int steps;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: step while idle, single point, shallow, steep, diagonal
        idle_step('1, 8'hff);
        draw_line(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 8'hff, 0);
        idle_step('0, 8'h00);
        draw_line(0, 0, 3, 1, 8'h5a, 3);
        draw_line(5, 5, 3, -1, 8'h01, 6);
        draw_line(-2, 2, 1, -1, 8'h80, 3);
        // abandon an extreme line with a new start
        draw_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 8'h00, 2);
        draw_line(10, 0, 12, -5, 8'hc3, 5);

        // A long line ending on the top edge of the range, walked to its end
        no_idle = ($urandom_range(0, 1) == 0);
        draw_line(COORD_MAX - 255, COORD_MIN, COORD_MAX, COORD_MIN + 97,
                  COLOR_BITS'($urandom), 255);

        // Random lines: mostly complete, some abandoned, a few wide
        while (sent_items < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 7) == 0);
            pick = $urandom_range(0, 99);
            x0 = int'($urandom_range(0, 4095)) + COORD_MIN;
            y0 = int'($urandom_range(0, 4095)) + COORD_MIN;
            if (pick < 92) begin
                x1 = near_coord(x0);
                y1 = near_coord(y0);
            end
            else begin
                x1 = int'($urandom_range(0, 4095)) + COORD_MIN;
                y1 = int'($urandom_range(0, 4095)) + COORD_MIN;
            end
            span_x = (x1 > x0) ? x1 - x0 : x0 - x1;
            span_y = (y1 > y0) ? y1 - y0 : y0 - y1;
            span = (span_x > span_y) ? span_x : span_y;
            if (pick < 80)
                steps = span + $urandom_range(0, 2);
            else if (pick < 92)
                steps = $urandom_range(0, span);
            else
                steps = $urandom_range(0, 20);
            draw_line(x0, y0, x1, y1, COLOR_BITS'($urandom), steps);
        end

        // Drain the pixels still owed, then watch for strays
        cmd_valid <= 1'b0;
        no_idle = 1'b0;
        while (tracker.owed_pixels.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
